FILE: sv/plpe_pkg.sv
`default_nettype none

package plpe_pkg;

	// Image geometry
	localparam int unsigned IMAGE_WIDTH   = 160;
	localparam int unsigned IMAGE_ROWS    = 200;
	localparam int unsigned BAND_BYTES    = IMAGE_WIDTH / 4 * 16;
	localparam int unsigned ROWS_PER_BAND = BAND_BYTES * 4 / IMAGE_WIDTH;
	localparam int unsigned READY_LEVEL   = 32'h280;
	localparam int unsigned TIMER_MAX     = 255;

	// Address widths: read port field, and widest store address (400 rows)
	localparam int unsigned ADDR_IN_W = 13;
	localparam int unsigned ADDR_W    = 14;

	// Item opcodes
	localparam logic [1:0] OP_LINK = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Packet commands
	localparam logic [7:0] CMD_CLEAR = 8'd1;
	localparam logic [7:0] CMD_PRINT = 8'd2;
	localparam logic [7:0] CMD_DATA  = 8'd4;

	// Link constants
	localparam logic [7:0] MAGIC_0     = 8'h88;
	localparam logic [7:0] MAGIC_1     = 8'h33;
	localparam logic [7:0] REPLY_ALIVE = 8'h81;

	// Status bits
	localparam logic [3:0] ST_READY     = 4'h8;
	localparam logic [3:0] ST_REQUESTED = 4'h4;
	localparam logic [3:0] ST_PRINTING  = 4'h2;
	localparam logic [3:0] ST_CHECKSUM  = 4'h1;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [7:0]           link_byte;
		logic [ADDR_IN_W-1:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic [3:0] status_bits;
		logic [7:0] store_data;
		logic [7:0] palette_value;
		logic [7:0] exposure_value;
	} out_item_t;

	// Image store write / clear controls
	typedef struct packed {
		logic              en;
		logic              clear;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

endpackage

`default_nettype wire

FILE: sv/plpe_store.sv
`default_nettype none

module plpe_store #(
	parameter int unsigned IMAGE_ROWS = plpe_pkg::IMAGE_ROWS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire plpe_pkg::store_wr_t            wr,
	input  wire logic                           rd_en,
	input  wire logic [plpe_pkg::ADDR_IN_W-1:0] rd_addr,
	output logic [7:0]                          rd_data
);

	localparam int unsigned StoreSize = plpe_pkg::IMAGE_WIDTH * IMAGE_ROWS / 4;
	localparam int unsigned AW        = $clog2(StoreSize);
	localparam int unsigned FW        = $clog2(StoreSize + 1);

	logic [7:0]    mem [StoreSize];
	logic [7:0]    mem_q;
	logic [FW-1:0] hwm_q;   // entries below this were written since the last clear
	logic          hit_q;

	// Writes always run upward from zero, so a high-water mark stands in for a
	// per-entry valid bit; anything at or above it reads as zero.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[AW'(wr.addr)] <= wr.data;
		end
		if (rd_en) begin
			mem_q <= mem[AW'(rd_addr)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr.clear) begin
				hwm_q <= '0;
			end else if (wr.en && (32'(wr.addr) >= 32'(hwm_q))) begin
				hwm_q <= FW'(32'(wr.addr) + 32'd1);
			end
			if (rd_en) begin
				hit_q <= 32'(rd_addr) < 32'(hwm_q);
			end
		end
	end

	assign rd_data = hit_q ? mem_q : 8'd0;

endmodule

`default_nettype wire

FILE: sv/printer_link_packet_engine.sv
// An accepted link byte, tick or read goes to S_DONE; its result is registered once
// the output register is free. item_ready is high only while idle, so no new item is
// taken before the last result has moved into the output register. A data byte passes
// through S_RUN, one byte stored or taken per cycle (a repeat run has up to 129 copies);
// a tick that starts a print counts 640-byte bands of filled store (up to 25 at 400 rows).
// Reset (arst_n low) clears all control and status state; the store reads as zero.
`default_nettype none

module printer_link_packet_engine #(
	parameter int unsigned IMAGE_ROWS = plpe_pkg::IMAGE_ROWS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire plpe_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output plpe_pkg::out_item_t      result
);

	localparam int unsigned StoreSize = plpe_pkg::IMAGE_WIDTH * IMAGE_ROWS / 4;
	localparam int unsigned FW        = $clog2(StoreSize + 1);
	localparam int unsigned KW        = $clog2(StoreSize / plpe_pkg::BAND_BYTES + 2);

	// Packet positions
	localparam logic [3:0] POS_MAGIC0 = 4'd0;
	localparam logic [3:0] POS_MAGIC1 = 4'd1;
	localparam logic [3:0] POS_CMD    = 4'd2;
	localparam logic [3:0] POS_FLAG   = 4'd3;
	localparam logic [3:0] POS_LEN_LO = 4'd4;
	localparam logic [3:0] POS_LEN_HI = 4'd5;
	localparam logic [3:0] POS_DATA   = 4'd6;
	localparam logic [3:0] POS_SUM_LO = 4'd7;
	localparam logic [3:0] POS_SUM_HI = 4'd8;
	localparam logic [3:0] POS_ALIVE  = 4'd9;
	localparam logic [3:0] POS_STATUS = 4'd10;

	typedef enum logic [1:0] {
		S_IDLE,   // waiting for an item
		S_RUN,    // one data byte into the store / parameters per cycle
		S_BAND,   // counting 640-byte bands of the fill for the print timer
		S_DONE    // result ready to move into the output register
	} state_t;

	state_t               state_q;
	plpe_pkg::out_item_t  result_q;
	logic                 result_valid_q;

	// Packet parser state
	logic [3:0]    pos_q;
	logic [7:0]    cmd_q;
	logic          comp_q;
	logic [15:0]   rem_q;
	logic [7:0]    run_ctl_q;
	logic [7:0]    run_left_q;
	logic [15:0]   sum_q;
	logic [15:0]   exp_q;
	logic [2:0]    pidx_q;

	// Printer state
	logic [3:0]    status_q;
	logic [7:0]    timer_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    palette_q;
	logic [7:0]    exposure_q;

	// Sequencer working registers
	logic [7:0]    data_q;       // byte being stored
	logic [7:0]    run_cnt_q;    // copies still to store
	logic [FW-1:0] band_rem_q;
	logic [KW-1:0] band_cnt_q;
	logic [7:0]    reply_q;
	logic          rd_sel_q;

	plpe_pkg::store_wr_t store_wr;
	logic [7:0]          store_rd_data;

	// Accept-cycle decode
	logic          item_fire;
	logic          link_fire;
	logic [7:0]    d;
	logic [3:0]    pos_eff;
	logic          sum_add;
	logic [15:0]   sum_next;
	logic [3:0]    st_chk;
	logic [3:0]    st_final;
	logic [FW-1:0] fill_after;
	logic [7:0]    run_len;
	logic [7:0]    timer_dec;
	logic [31:0]   rows_w;
	logic [7:0]    rows_sat;
	logic          store_room;

	assign item_fire = item_valid && item_ready;
	assign link_fire = item_fire && (item.opcode == plpe_pkg::OP_LINK);
	assign d         = item.link_byte;

	// Zero data length drops straight through to the checksum bytes
	assign pos_eff  = ((pos_q == POS_DATA) && (rem_q == 16'd0)) ? POS_SUM_LO : pos_q;
	assign sum_add  = !(pos_eff inside {POS_MAGIC0, POS_MAGIC1, POS_SUM_LO, POS_SUM_HI});
	assign sum_next = sum_add ? (sum_q + 16'(d)) : sum_q;

	// Status byte handling: checksum bit, then a clear wipes everything
	always_comb begin
		st_chk = (sum_next != exp_q) ? (status_q | plpe_pkg::ST_CHECKSUM)
		                             : (status_q & ~plpe_pkg::ST_CHECKSUM);
		fill_after = fill_q;
		if (cmd_q == plpe_pkg::CMD_CLEAR) begin
			st_chk     = 4'd0;
			fill_after = '0;
		end
		st_final = (32'(fill_after) >= plpe_pkg::READY_LEVEL)
		           ? (st_chk | plpe_pkg::ST_READY) : st_chk;
	end

	// Control byte: literal run is c+1 bytes, repeat run is (c & 0x7f)+2 copies
	assign run_len   = 8'({1'b0, d[6:0]}) + 8'd1 + 8'(d[7]);
	assign timer_dec = timer_q - 8'd1;

	// Print height: 16 rows per band, at least 1, saturating at 255
	assign rows_w   = 32'(band_cnt_q) * plpe_pkg::ROWS_PER_BAND;
	assign rows_sat = (rows_w == 32'd0) ? 8'd1 :
	                  (rows_w > plpe_pkg::TIMER_MAX) ? 8'(plpe_pkg::TIMER_MAX) : 8'(rows_w);

	assign store_room = 32'(fill_q) < StoreSize;

	always_comb begin
		store_wr.en    = (state_q == S_RUN) && (cmd_q == plpe_pkg::CMD_DATA) && store_room;
		store_wr.clear = link_fire && (pos_eff == POS_STATUS) &&
		                 (cmd_q == plpe_pkg::CMD_CLEAR);
		store_wr.addr  = plpe_pkg::ADDR_W'(fill_q);
		store_wr.data  = data_q;
	end

	plpe_store #(
		.IMAGE_ROWS(IMAGE_ROWS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (store_wr),
		.rd_en   (item_fire && (item.opcode == plpe_pkg::OP_READ)),
		.rd_addr (item.read_address),
		.rd_data (store_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			pos_q          <= POS_MAGIC0;
			cmd_q          <= 8'd0;
			comp_q         <= 1'b0;
			rem_q          <= 16'd0;
			run_ctl_q      <= 8'd0;
			run_left_q     <= 8'd0;
			sum_q          <= 16'd0;
			exp_q          <= 16'd0;
			pidx_q         <= 3'd0;
			status_q       <= 4'd0;
			timer_q        <= 8'd0;
			fill_q         <= '0;
			palette_q      <= 8'd0;
			exposure_q     <= 8'd0;
			data_q         <= 8'd0;
			run_cnt_q      <= 8'd0;
			band_rem_q     <= '0;
			band_cnt_q     <= '0;
			reply_q        <= 8'd0;
			rd_sel_q       <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						reply_q  <= 8'd0;
						rd_sel_q <= item.opcode == plpe_pkg::OP_READ;
						state_q  <= S_DONE;
						case (item.opcode)
							plpe_pkg::OP_LINK: begin
								sum_q <= sum_next;
								pos_q <= pos_eff + 4'd1;
								case (pos_eff)
									POS_MAGIC0: begin
										if (d != plpe_pkg::MAGIC_0) begin
											pos_q  <= POS_MAGIC0;
											sum_q  <= 16'd0;
											pidx_q <= 3'd0;
										end
									end
									POS_MAGIC1: begin
										if (d != plpe_pkg::MAGIC_1) begin
											pos_q  <= POS_MAGIC0;
											sum_q  <= 16'd0;
											pidx_q <= 3'd0;
										end
									end
									POS_CMD: cmd_q <= d;
									POS_FLAG: begin
										comp_q <= d != 8'd0;
										if (d != 8'd0) begin
											run_left_q <= 8'd0;
										end
									end
									POS_LEN_LO: rem_q <= {8'd0, d};
									POS_LEN_HI: rem_q <= {d, rem_q[7:0]};
									POS_DATA: begin
										pos_q <= POS_DATA;
										rem_q <= rem_q - 16'd1;
										data_q <= d;
										if (!comp_q) begin
											run_cnt_q <= 8'd1;
											state_q   <= S_RUN;
										end else if (run_left_q == 8'd0) begin
											run_ctl_q  <= d;
											run_left_q <= run_len;
										end else if (run_ctl_q[7]) begin
											// repeat run: all remaining copies now
											run_cnt_q  <= run_left_q;
											run_left_q <= 8'd0;
											state_q    <= S_RUN;
										end else begin
											run_cnt_q  <= 8'd1;
											run_left_q <= run_left_q - 8'd1;
											state_q    <= S_RUN;
										end
									end
									POS_SUM_LO: exp_q <= {8'd0, d};
									POS_SUM_HI: exp_q <= {d, exp_q[7:0]};
									POS_ALIVE:  reply_q <= plpe_pkg::REPLY_ALIVE;
									POS_STATUS: begin
										reply_q  <= {4'd0, st_chk};
										status_q <= st_final;
										fill_q   <= fill_after;
										if (cmd_q == plpe_pkg::CMD_CLEAR) begin
											timer_q <= 8'd0;
										end else if (cmd_q == plpe_pkg::CMD_PRINT) begin
											timer_q <= 8'd1;
										end
										pos_q  <= POS_MAGIC0;
										sum_q  <= 16'd0;
										pidx_q <= 3'd0;
									end
									default: begin
										pos_q  <= POS_MAGIC0;
										sum_q  <= 16'd0;
										pidx_q <= 3'd0;
									end
								endcase
							end
							plpe_pkg::OP_TICK: begin
								if (timer_q != 8'd0) begin
									timer_q <= timer_dec;
									if (timer_dec == 8'd0) begin
										if ((status_q & plpe_pkg::ST_PRINTING) != 4'd0) begin
											status_q <= status_q & ~plpe_pkg::ST_PRINTING;
										end else begin
											status_q <= (status_q | plpe_pkg::ST_REQUESTED |
											             plpe_pkg::ST_PRINTING) &
											            ~plpe_pkg::ST_READY;
											band_rem_q <= fill_q;
											band_cnt_q <= '0;
											state_q    <= S_BAND;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end

				S_RUN: begin
					if (cmd_q == plpe_pkg::CMD_PRINT) begin
						if (pidx_q == 3'd2) begin
							palette_q <= data_q;
						end else if (pidx_q == 3'd3) begin
							exposure_q <= data_q;
						end
						if (pidx_q < 3'd4) begin
							pidx_q <= pidx_q + 3'd1;
						end
					end else if ((cmd_q == plpe_pkg::CMD_DATA) && store_room) begin
						fill_q <= fill_q + FW'(1);
					end
					run_cnt_q <= run_cnt_q - 8'd1;
					if (run_cnt_q == 8'd1) begin
						state_q <= S_DONE;
					end
				end

				S_BAND: begin
					// ceil(fill / 640), one subtract per cycle
					if (band_rem_q == '0) begin
						timer_q <= rows_sat;
						fill_q  <= '0;
						state_q <= S_DONE;
					end else begin
						band_cnt_q <= band_cnt_q + KW'(1);
						if (32'(band_rem_q) > plpe_pkg::BAND_BYTES) begin
							band_rem_q <= band_rem_q - FW'(plpe_pkg::BAND_BYTES);
						end else begin
							band_rem_q <= '0;
						end
					end
				end

				S_DONE: begin
					if (!result_valid_q || result_ready) begin
						result_q.reply_byte     <= reply_q;
						result_q.status_bits    <= status_q;
						result_q.store_data     <= rd_sel_q ? store_rd_data : 8'd0;
						result_q.palette_value  <= palette_q;
						result_q.exposure_value <= exposure_q;
						result_valid_q          <= 1'b1;
						state_q                 <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready   = state_q == S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> run_cnt_q != 8'd0)
		else $error("store run entered with zero count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= StoreSize)
		else $error("fill index beyond store");

	a_print_flags: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[1] |-> status_q[2])
		else $error("printing without requested");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire

FILE: sim/printer_link_packet_engine_test.sv
`timescale 1ns / 100ps

module printer_link_packet_engine_test;
	import plpe_pkg::*;

	// smallest image height keeps a store overflow short
	localparam int TEST_ROWS     = 16;
	localparam int STORE_SIZE    = IMAGE_WIDTH * TEST_ROWS / 4;
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int STALL_LIMIT   = 40000; // cycles with no handshake at all
	localparam int SETTLE_CYCLES = 200;   // repeat runs and band counting

	// opcode the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// packet byte positions
	localparam bit [3:0] POS_MAGIC0 = 4'd0;
	localparam bit [3:0] POS_MAGIC1 = 4'd1;
	localparam bit [3:0] POS_CMD    = 4'd2;
	localparam bit [3:0] POS_FLAG   = 4'd3;
	localparam bit [3:0] POS_LEN_LO = 4'd4;
	localparam bit [3:0] POS_LEN_HI = 4'd5;
	localparam bit [3:0] POS_DATA   = 4'd6;
	localparam bit [3:0] POS_SUM_LO = 4'd7;
	localparam bit [3:0] POS_SUM_HI = 4'd8;
	localparam bit [3:0] POS_ALIVE  = 4'd9;
	localparam bit [3:0] POS_STATUS = 4'd10;

	// Printer-side behavior, one step per accepted item, plus the queue of
	// replies the block still owes us.
	class reply_scoreboard;
		bit [3:0]  pos;
		bit [7:0]  command;
		bit        compressed;
		bit [15:0] remaining;
		bit [7:0]  run_ctl;
		bit [7:0]  run_left;
		bit [15:0] sum;
		bit [15:0] sum_sent;
		bit [2:0]  param_idx;
		bit [3:0]  status;
		bit [7:0]  timer;
		bit [13:0] fill;
		bit [7:0]  store [STORE_SIZE];
		bit [7:0]  palette;
		bit [7:0]  exposure;

		out_item_t expected_replies[$];
		int errors;
		int results_checked;
		int prints_started;
		int bad_sums_seen;
		int bytes_dropped;

		function void drop_packet();
			pos = POS_MAGIC0;
			sum = 16'd0;
			param_idx = 3'd0;
		endfunction

		function void clear_printer();
			status = 4'd0;
			fill = 14'd0;
			foreach (store[i])
				store[i] = 8'd0;
			timer = 8'd0;
		endfunction

		function void take_byte(bit [7:0] d);
			if (command == CMD_PRINT) begin
				if (param_idx == 3'd2)
					palette = d;
				else if (param_idx == 3'd3)
					exposure = d;
				if (param_idx < 3'd4)
					param_idx++;
			end else if (command == CMD_DATA) begin
				if (fill < STORE_SIZE) begin
					store[fill] = d;
					fill++;
				end else begin
					bytes_dropped++;
				end
			end
		endfunction

		function void start_print();
			int unsigned idx;
			int unsigned rows;
			idx = fill;
			if (idx % BAND_BYTES != 0)
				idx += BAND_BYTES - idx % BAND_BYTES;
			rows = idx / IMAGE_WIDTH * 4;
			fill = 14'd0;
			if (rows == 0)
				rows = 1;
			if (rows > TIMER_MAX)
				rows = TIMER_MAX;
			timer = rows[7:0];
			prints_started++;
		endfunction

		function void frame_tick();
			if (timer == 8'd0)
				return;
			timer--;
			if (timer != 8'd0)
				return;
			if ((status & ST_PRINTING) != 4'd0) begin
				status &= ~ST_PRINTING;
			end else begin
				status |= ST_REQUESTED | ST_PRINTING;
				status &= ~ST_READY;
				start_print();
			end
		endfunction

		function bit [7:0] link_step(bit [7:0] d);
			bit [7:0] reply;
			reply = 8'd0;
			if (pos == POS_DATA && remaining == 16'd0)
				pos = POS_SUM_LO;
			if (pos != POS_MAGIC0 && pos != POS_MAGIC1 && pos != POS_SUM_LO &&
			    pos != POS_SUM_HI)
				sum += d;
			case (pos)
			POS_MAGIC0: begin
				if (d != MAGIC_0) begin
					drop_packet();
					return 8'd0;
				end
			end
			POS_MAGIC1: begin
				if (d != MAGIC_1) begin
					drop_packet();
					return 8'd0;
				end
			end
			POS_CMD: command = d;
			POS_FLAG: begin
				compressed = (d != 8'd0);
				if (compressed)
					run_left = 8'd0;
			end
			POS_LEN_LO: remaining = {8'd0, d};
			POS_LEN_HI: remaining = {d, remaining[7:0]};
			POS_DATA: begin
				if (!compressed) begin
					take_byte(d);
				end else if (run_left == 8'd0) begin
					run_ctl = d;
					run_left = (d & 8'h7f) + 8'd1;
					if (d[7])
						run_left++;
				end else if (run_ctl[7]) begin
					while (run_left != 8'd0) begin
						take_byte(d);
						run_left--;
					end
				end else begin
					take_byte(d);
					run_left--;
				end
				remaining--;
				return 8'd0;
			end
			POS_SUM_LO: sum_sent = {8'd0, d};
			POS_SUM_HI: sum_sent = {d, sum_sent[7:0]};
			POS_ALIVE: reply = REPLY_ALIVE;
			POS_STATUS: begin
				if (sum != sum_sent) begin
					status |= ST_CHECKSUM;
					bad_sums_seen++;
				end else begin
					status &= ~ST_CHECKSUM;
				end
				if (command == CMD_CLEAR)
					clear_printer();
				else if (command == CMD_PRINT)
					timer = 8'd1;
				reply = {4'd0, status};
				if (fill >= READY_LEVEL)
					status |= ST_READY;
				drop_packet();
				return reply;
			end
			default: begin
				drop_packet();
				return 8'd0;
			end
			endcase
			pos++;
			return reply;
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			r = '0;
			case (it.opcode)
			OP_LINK: r.reply_byte = link_step(it.link_byte);
			OP_TICK: frame_tick();
			OP_READ: begin
				if (it.read_address < STORE_SIZE)
					r.store_data = store[it.read_address];
			end
			default: ;
			endcase
			r.status_bits = status;
			r.palette_value = palette;
			r.exposure_value = exposure;
			expected_replies.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results_checked++;
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result reply=%h status=%h store=%h pal=%h exp=%h",
					$time, got.reply_byte, got.status_bits, got.store_data,
					got.palette_value, got.exposure_value);
				return;
			end
			want = expected_replies.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: expected reply=%h status=%h store=%h pal=%h exp=%h, %s",
					$time, want.reply_byte, want.status_bits, want.store_data,
					want.palette_value, want.exposure_value,
					$sformatf("actual reply=%h status=%h store=%h pal=%h exp=%h",
						got.reply_byte, got.status_bits, got.store_data,
						got.palette_value, got.exposure_value));
			end
		endfunction
	endclass

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	reply_scoreboard sb = new;

	// idle percentages per phase, set by the stimulus process
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request  = 1'b0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	// stimulus bookkeeping
	int items_sent   = 0;
	int packets_sent = 0;
	int op_count [4];
	logic [7:0] pkt_body[$];  // data bytes of the next packet

	printer_link_packet_engine #(
		.IMAGE_ROWS(TEST_ROWS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #10 clk = ~clk;

	// Result side: check whatever was taken at this edge, then pick ready for
	// the next cycle. A hold-off request parks ready low for a long stretch so
	// the block backs up into its input.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: any handshake counts as progress.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one item, with random idle cycles first. Valid stays high from one
	// item to the next unless a gap is drawn, so it never drops and rises in
	// the same step.
	task automatic send_item(input logic [1:0] op, input logic [7:0] b,
	                         input logic [ADDR_IN_W-1:0] a);
		in_item_t next_item;
		next_item.opcode = op;
		next_item.link_byte = b;
		next_item.read_address = a;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= next_item;
		@(posedge clk);
		while (item_ready !== 1'b1)
			@(posedge clk);
		sb.note_item(item);
		items_sent++;
		op_count[op]++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count)
			send_item(OP_TICK, 8'($urandom), 13'($urandom));
	endtask

	// Append well-formed RLE runs to pkt_body. Wide runs push the fill level
	// toward the ready threshold quickly.
	task automatic build_runs(input int runs, input bit wide);
		int n;
		repeat (runs) begin
			if ($urandom_range(1)) begin
				n = $urandom_range(0, 5);
				pkt_body.push_back(8'(n));
				repeat (n + 1)
					pkt_body.push_back(8'($urandom));
			end else begin
				n = wide ? $urandom_range(64, 127) : $urandom_range(0, 10);
				pkt_body.push_back(8'h80 | 8'(n));
				pkt_body.push_back(8'($urandom));
			end
		end
	endtask

	// Frame pkt_body as a packet. The checksum covers command, flag, length,
	// data and the host's own alive and status bytes. stop_after < 0 sends the
	// whole packet, otherwise only that many bytes of it.
	task automatic send_packet(input logic [7:0] cmd, input logic [7:0] flag,
	                           input logic [15:0] len, input bit bad_sum,
	                           input int stop_after);
		logic [7:0]  frame[$];
		logic [15:0] csum;
		logic [7:0]  alive;
		logic [7:0]  host_status;
		alive = 8'($urandom);
		host_status = 8'($urandom);
		csum = cmd + flag + len[7:0] + len[15:8] + alive + host_status;
		foreach (pkt_body[i])
			csum += pkt_body[i];
		if (bad_sum)
			csum ^= 16'h1 << $urandom_range(15);
		frame = {MAGIC_0, MAGIC_1, cmd, flag, len[7:0], len[15:8]};
		frame = {frame, pkt_body};
		frame.push_back(csum[7:0]);
		frame.push_back(csum[15:8]);
		frame.push_back(alive);
		frame.push_back(host_status);
		foreach (frame[i])
			if (stop_after < 0 || i < stop_after)
				send_item(OP_LINK, frame[i], 13'($urandom));
		pkt_body.delete();
		packets_sent++;
	endtask

	// One randomly chosen piece of host traffic: mostly well-formed packets
	// with random content, plus ticks, reads, noise and broken packets.
	task automatic random_sequence();
		int pick;
		int n;
		logic [7:0] flag;
		logic [ADDR_IN_W-1:0] addr;
		pick = $urandom_range(99);
		if (pick < 30) begin
			// image data, raw or run-length coded
			if ($urandom_range(1)) begin
				build_runs($urandom_range(1, 4), $urandom_range(3) == 0);
				flag = 8'($urandom_range(1, 255));
			end else begin
				repeat ($urandom_range(0, 12))
					pkt_body.push_back(8'($urandom));
				flag = 8'h00;
			end
			send_packet(CMD_DATA, flag, 16'(pkt_body.size()), $urandom_range(9) == 0, -1);
		end else if (pick < 45) begin
			// print: params sit at data bytes 2 and 3; short bodies leave them
			repeat ($urandom_range(0, 6))
				pkt_body.push_back(8'($urandom));
			send_packet(CMD_PRINT, 8'h00, 16'(pkt_body.size()), $urandom_range(9) == 0, -1);
			send_ticks($urandom_range(1, 20));
		end else if (pick < 52) begin
			send_packet(CMD_CLEAR, 8'h00, 16'd0, $urandom_range(4) == 0, -1);
		end else if (pick < 57) begin
			// any command byte, any flag
			repeat ($urandom_range(0, 4))
				pkt_body.push_back(8'($urandom));
			send_packet(8'($urandom), 8'($urandom), 16'(pkt_body.size()), 1'b0, -1);
		end else if (pick < 72) begin
			send_ticks($urandom_range(1, 24));
		end else if (pick < 84) begin
			repeat ($urandom_range(1, 4)) begin
				n = $urandom_range(2);
				addr = (n == 0) ? 13'($urandom_range(0, 31)) :
				       (n == 1) ? 13'($urandom_range(0, STORE_SIZE - 1)) : 13'($urandom);
				send_item(OP_READ, 8'($urandom), addr);
			end
		end else if (pick < 92) begin
			repeat ($urandom_range(1, 3))
				send_item($urandom_range(1) ? OP_LINK : OP_UNUSED, 8'($urandom),
					13'($urandom));
		end else begin
			n = $urandom_range(2);
			if (n == 0) begin
				// good first magic, bad second
				send_item(OP_LINK, MAGIC_0, 13'($urandom));
				send_item(OP_LINK, MAGIC_1 ^ 8'($urandom_range(1, 255)), 13'($urandom));
			end else if (n == 1) begin
				// packet cut short; what follows lands mid-packet
				repeat ($urandom_range(0, 6))
					pkt_body.push_back(8'($urandom));
				send_packet(CMD_DATA, 8'h00, 16'(pkt_body.size()), 1'b0,
					$urandom_range(3, 6 + pkt_body.size()));
			end else begin
				// length one short of the runs sent
				build_runs(2, 1'b0);
				send_packet(CMD_DATA, 8'h80, 16'(pkt_body.size() - 1), 1'b0, -1);
			end
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			random_sequence();
	endtask

	// Sender pause until every owed reply is back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (sb.expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads at the store ends and past them on a fresh store
		send_item(OP_READ, 8'hFF, 13'd0);
		send_item(OP_READ, 8'h00, 13'(STORE_SIZE - 1));
		send_item(OP_READ, 8'h5A, 13'(STORE_SIZE));
		send_item(OP_READ, 8'hA5, 13'h1FFF);
		// unused opcode, and a tick with no print timer running
		send_item(OP_UNUSED, 8'hFF, 13'h1FFF);
		send_item(OP_TICK, 8'h00, 13'd0);
		// bad first magic, then bad second magic
		send_item(OP_LINK, 8'h00, 13'h0AAA);
		send_item(OP_LINK, MAGIC_0, 13'h1555);
		send_item(OP_LINK, 8'h34, 13'd0);
		// compressed image data: literal run of two, then a repeat run of two
		pkt_body = {8'h01, 8'hA5, 8'h5A, 8'h80, 8'hC3};
		send_packet(CMD_DATA, 8'hFF, 16'd5, 1'b0, -1);
		send_item(OP_READ, 8'h00, 13'd0);
		send_item(OP_READ, 8'hFF, 13'd3);
		wait_drained();

		// Sender mostly busy, receiver mostly stalled; opens with a long
		// hold-off so the block backs up.
		send_idle_pct = 10;
		recv_idle_pct = 84;
		hold_request <= 1'b1;
		run_random(12);
		wait_drained();

		// Sender mostly idle, receiver mostly ready
		send_idle_pct = 84;
		recv_idle_pct = 10;
		run_random(10);
		wait_drained();

		// Full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(10);

		// Store overflow: clear, then repeat runs of 129 copies run past the
		// store end. Read the last byte, then print from a full store.
		send_packet(CMD_CLEAR, 8'h00, 16'd0, 1'b0, -1);
		repeat (STORE_SIZE / 129 + 1) begin
			pkt_body.push_back(8'hFF);
			pkt_body.push_back(8'($urandom));
		end
		send_packet(CMD_DATA, 8'h01, 16'(pkt_body.size()), 1'b0, -1);
		send_item(OP_READ, 8'($urandom), 13'(STORE_SIZE - 1));
		send_item(OP_READ, 8'($urandom), 13'd0);
		repeat (4)
			pkt_body.push_back(8'($urandom));
		send_packet(CMD_PRINT, 8'h00, 16'd4, 1'b0, -1);
		send_ticks(3);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items in %0d packets: %0d link bytes, %0d ticks, %0d reads, %0d unused.",
			items_sent, packets_sent, op_count[OP_LINK], op_count[OP_TICK],
			op_count[OP_READ], op_count[OP_UNUSED]);
		$display("%0d results checked; %0d prints started, %0d bad checksums, %0d bytes past store end.",
			sb.results_checked, sb.prints_started, sb.bad_sums_seen, sb.bytes_dropped);
		if (sb.errors == 0 && sb.expected_replies.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
